### hdl/frame_header_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// frame header receiver assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FRAME_HEADER_RECEIVER_UNIT_ASSERT_SVH
`define FRAME_HEADER_RECEIVER_UNIT_ASSERT_SVH

// next-cycle implication, also checked while reset is applied
`define FRHU_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frame header receiver: check failed");

// next-cycle implication, masked while reset is applied
`define FRHU_ASSERT_NEXT_RST(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame header receiver: check failed");

`endif

### hdl/frh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frh_pkg
// types, constants and helper functions of the frame header receiver
// ----------------------------------------------------------------------------
package frh_pkg;

    localparam int unsigned HDR_LEN  = 48;
    localparam int unsigned CRC_OFS  = 44;
    localparam int unsigned SYNC_LEN = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [7:0] SYNC_MARK [SYNC_LEN] = '{8'h4E, 8'h53, 8'h4E, 8'h4E};
    localparam logic [2:0] KMP_BACK  [SYNC_LEN] = '{3'd0, 3'd0, 3'd1, 3'd1};

    localparam logic [2:0] MATCH_DONE = 3'(SYNC_LEN);
    localparam logic [5:0] POS_FIRST  = 6'(SYNC_LEN);
    localparam logic [5:0] POS_LAST   = 6'(HDR_LEN - 1);
    localparam logic [5:0] POS_CRC    = 6'(CRC_OFS);
    localparam logic [5:0] POS_CRC_M1 = 6'(CRC_OFS - 1);

    // header field offsets
    localparam logic [5:0] OFS_VERSION  = 6'd4;
    localparam logic [5:0] OFS_MSG_TYPE = 6'd5;
    localparam logic [5:0] OFS_SIZE     = 6'd6;
    localparam logic [5:0] OFS_SEQ      = 6'd8;
    localparam logic [5:0] OFS_PLEN     = 6'd12;
    localparam logic [5:0] OFS_PCRC     = 6'd16;
    localparam logic [5:0] OFS_DIM0     = 6'd24;
    localparam logic [5:0] OFS_DIM1     = 6'd26;
    localparam logic [5:0] OFS_DIM2     = 6'd28;
    localparam logic [5:0] OFS_DTYPE    = 6'd30;

    localparam logic [15:0] HDR_SIZE = 16'(HDR_LEN);

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [5:0] pos;
        logic [7:0] data;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_beat;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_of_mark();
        logic [31:0] c;
        c = CRC_INIT;
        for (int i = 0; i < SYNC_LEN; i++) begin
            c = crc_byte(c, SYNC_MARK[i]);
        end
        return c;
    endfunction

    // crc register once the sync mark has been folded in
    localparam logic [31:0] CRC_AFTER_MARK = crc_of_mark();

    // prefix-function step of the sync mark matcher, m below SYNC_LEN
    function automatic logic [2:0] kmp_next(input logic [2:0] m, input logic [7:0] b);
        logic [2:0] k;
        k = m;
        for (int i = 0; i < SYNC_LEN - 1; i++) begin
            if (k != 3'd0 && b != SYNC_MARK[k[1:0]]) begin
                k = KMP_BACK[k[1:0] - 2'd1];
            end
        end
        if (b == SYNC_MARK[k[1:0]]) begin
            k = k + 3'd1;
        end
        return k;
    endfunction

endpackage

### hdl/frame_header_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_header_receiver_unit
// byte-stream deframer: sync mark hunt, 48-byte header capture and check
// ----------------------------------------------------------------------------
// takes one received byte per beat on i_valid/o_ready and, while o_ready is
// high, sustains one byte every clock cycle. the front end hunts for the
// four-byte sync mark with a prefix-function matcher and numbers the 44
// header bytes that follow it; the back end runs the reflected crc-32 over
// header bytes 0 to 43 one byte per cycle, folds in the stored crc from
// bytes 44 to 47 and captures the little-endian fields. a four-beat queue
// sits between the two, so o_ready only drops when that queue fills, which
// happens only while a finished result is held on the output and the back
// end holds the next header's last byte. o_valid rises once the back end
// pops the last header byte and holds until i_ready. o_result_code is 0 for
// a good header and 1 for a version, size or header crc mismatch; all fields
// are still given on a bad header. expected version (reset 1) is written
// through i_cfg_we/i_cfg_wdata only while the block is idle, a rule on the
// user that the block does not enforce. bytes after a found mark are always
// header data; the hunt restarts after the last header byte.
module frame_header_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // received byte stream
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    // header result
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_code,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_seq_number,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_payload_crc,
    output logic [15:0] o_dim_zero,
    output logic [15:0] o_dim_one,
    output logic [15:0] o_dim_two,
    output logic [15:0] o_data_type
);

    frh_pkg::t_q_beat q_wr;
    frh_pkg::t_q_beat q_rd;
    logic             q_full;
    logic             q_pop;

    // mark hunt and byte numbering
    frh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr)
    );

    // decouples intake from the result stall
    frh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    // crc, field capture and verdict
    frh_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_rd             (q_rd),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_code    (o_result_code),
        .o_msg_type       (o_msg_type),
        .o_seq_number     (o_seq_number),
        .o_payload_length (o_payload_length),
        .o_payload_crc    (o_payload_crc),
        .o_dim_zero       (o_dim_zero),
        .o_dim_one        (o_dim_one),
        .o_dim_two        (o_dim_two),
        .o_data_type      (o_data_type)
    );

endmodule

### hdl/frh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frh_front
// byte intake: sync mark hunt and header byte numbering
// ----------------------------------------------------------------------------
module frh_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_q_full,
    output frh_pkg::t_q_beat o_q_wr
);

    logic [2:0] r_matched;
    logic [2:0] n_matched;
    logic [5:0] r_pos;
    logic [5:0] n_pos;
    logic       accept;
    logic       collecting;

    assign o_ready    = !i_q_full;
    assign accept     = i_valid && !i_q_full;
    assign collecting = (r_matched == frh_pkg::MATCH_DONE);

    always_comb begin
        n_matched         = r_matched;
        n_pos             = r_pos;
        o_q_wr.valid      = accept && collecting;
        o_q_wr.entry.pos  = r_pos;
        o_q_wr.entry.data = i_rx_byte;
        if (accept) begin
            if (!collecting) begin
                n_matched = frh_pkg::kmp_next(r_matched, i_rx_byte);
                if (n_matched == frh_pkg::MATCH_DONE) begin
                    n_pos = frh_pkg::POS_FIRST;
                end
            end else if (r_pos == frh_pkg::POS_LAST) begin
                n_matched = 3'd0;
                n_pos     = 6'd0;
            end else begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= 3'd0;
            r_pos     <= 6'd0;
        end else begin
            r_matched <= n_matched;
            r_pos     <= n_pos;
        end
    end

endmodule

### hdl/frh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frh_queue
// short fifo of numbered header bytes between front and back
// ----------------------------------------------------------------------------
module frh_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frh_pkg::t_q_beat i_wr,
    output logic             o_full,
    output frh_pkg::t_q_beat o_rd,
    input  logic             i_pop
);

    frh_pkg::t_q_entry r_mem [frh_pkg::Q_DEPTH];
    logic [frh_pkg::Q_AW-1:0] r_wr_ptr;
    logic [frh_pkg::Q_AW-1:0] r_rd_ptr;
    logic [frh_pkg::Q_CW-1:0] r_count;
    logic [frh_pkg::Q_CW-1:0] n_count;

    assign o_full     = (r_count == frh_pkg::Q_CW'(frh_pkg::Q_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

endmodule

### hdl/frh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frh_back
// header crc, field capture, verdict and result register
// ----------------------------------------------------------------------------
module frh_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  frh_pkg::t_q_beat i_rd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_result_code,
    output logic [7:0]       o_msg_type,
    output logic [31:0]      o_seq_number,
    output logic [31:0]      o_payload_length,
    output logic [31:0]      o_payload_crc,
    output logic [15:0]      o_dim_zero,
    output logic [15:0]      o_dim_one,
    output logic [15:0]      o_dim_two,
    output logic [15:0]      o_data_type
);

    logic [7:0]  r_expected_version;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] crc_base;
    logic [5:0]  crc_rel;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic        is_last;
    logic        bad;

    // header fields being collected
    logic [7:0]  r_version;
    logic [7:0]  r_msg_type;
    logic [15:0] r_size;
    logic [31:0] r_seq;
    logic [31:0] r_plen;
    logic [31:0] r_pcrc;
    logic [15:0] r_dim0;
    logic [15:0] r_dim1;
    logic [15:0] r_dim2;
    logic [15:0] r_dtype;

    assign pos     = i_rd.entry.pos;
    assign data    = i_rd.entry.data;
    assign is_last = (pos == frh_pkg::POS_LAST);
    assign o_pop   = i_rd.valid && (!is_last || !r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign crc_rel = pos - frh_pkg::POS_CRC;

    always_comb begin
        crc_base = (pos == frh_pkg::POS_FIRST) ? frh_pkg::CRC_AFTER_MARK : r_crc;
        if (pos < frh_pkg::POS_CRC) begin
            n_crc = frh_pkg::crc_byte(crc_base, data);
            if (pos == frh_pkg::POS_CRC_M1) begin
                n_crc = ~n_crc;
            end
        end else begin
            // fold stored crc bytes in, zero at the end on a match
            n_crc = r_crc ^ ({24'h000000, data} << {crc_rel[1:0], 3'b000});
        end
    end

    assign bad = (r_version != r_expected_version) || (r_size != frh_pkg::HDR_SIZE)
                 || (n_crc != 32'h00000000);

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop && is_last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= 8'd1;
            r_out_valid        <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_expected_version <= i_cfg_wdata;
            end
        end
    end

    // multi-byte fields sit on aligned offsets, so low position bits pick the lane
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_crc <= n_crc;
            unique case (pos) inside
                frh_pkg::OFS_VERSION:  r_version  <= data;
                frh_pkg::OFS_MSG_TYPE: r_msg_type <= data;
                [frh_pkg::OFS_SIZE : frh_pkg::OFS_SIZE + 6'd1]:
                    r_size[{pos[0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_SEQ : frh_pkg::OFS_SEQ + 6'd3]:
                    r_seq[{pos[1:0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_PLEN : frh_pkg::OFS_PLEN + 6'd3]:
                    r_plen[{pos[1:0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_PCRC : frh_pkg::OFS_PCRC + 6'd3]:
                    r_pcrc[{pos[1:0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_DIM0 : frh_pkg::OFS_DIM0 + 6'd1]:
                    r_dim0[{pos[0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_DIM1 : frh_pkg::OFS_DIM1 + 6'd1]:
                    r_dim1[{pos[0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_DIM2 : frh_pkg::OFS_DIM2 + 6'd1]:
                    r_dim2[{pos[0], 3'b000} +: 8] <= data;
                [frh_pkg::OFS_DTYPE : frh_pkg::OFS_DTYPE + 6'd1]:
                    r_dtype[{pos[0], 3'b000} +: 8] <= data;
                default: ;
            endcase
        end
        if (o_pop && is_last) begin
            o_result_code    <= bad;
            o_msg_type       <= r_msg_type;
            o_seq_number     <= r_seq;
            o_payload_length <= r_plen;
            o_payload_crc    <= r_pcrc;
            o_dim_zero       <= r_dim0;
            o_dim_one        <= r_dim1;
            o_dim_two        <= r_dim2;
            o_data_type      <= r_dtype;
        end
    end

endmodule

### hdl/frh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frh_checker
// port-level checks of the frame header receiver
// ----------------------------------------------------------------------------
`include "frame_header_receiver_unit_assert.svh"

module frh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_result_code,
    input logic [7:0]  o_msg_type,
    input logic [31:0] o_seq_number,
    input logic [31:0] o_payload_length,
    input logic [31:0] o_payload_crc,
    input logic [15:0] o_dim_zero,
    input logic [15:0] o_dim_one,
    input logic [15:0] o_dim_two,
    input logic [15:0] o_data_type
);

    logic [168:0] result;

    assign result = {o_result_code, o_msg_type, o_seq_number, o_payload_length,
                     o_payload_crc, o_dim_zero, o_dim_one, o_dim_two, o_data_type};

    // no result straight out of reset
    `FRHU_ASSERT_NEXT(a_no_result_after_rst, i_clk, !i_rst_n, !o_valid)
    // queue empty after reset, so intake is open
    `FRHU_ASSERT_NEXT(a_ready_after_rst, i_clk, !i_rst_n, o_ready)
    // stalled result beat holds
    `FRHU_ASSERT_NEXT_RST(a_result_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `FRHU_ASSERT_NEXT_RST(a_result_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(result))

endmodule

bind frame_header_receiver_unit frh_checker u_frh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_result_code    (o_result_code),
    .o_msg_type       (o_msg_type),
    .o_seq_number     (o_seq_number),
    .o_payload_length (o_payload_length),
    .o_payload_crc    (o_payload_crc),
    .o_dim_zero       (o_dim_zero),
    .o_dim_one        (o_dim_one),
    .o_dim_two        (o_dim_two),
    .o_data_type      (o_data_type)
);
